>>> src/urlpd_pkg.sv
// ----------------------------------------------------------------------------
// urlpd_pkg
// Shared types, character codes and helper functions of the URL decoder.
// ----------------------------------------------------------------------------
package urlpd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam int unsigned GrpDepth = 3;

  // Result bytes caused by one item, slot 0 leaves first.
  typedef struct packed {
    logic [1:0]                   cnt;
    logic [GrpDepth-1:0][7:0]     data;
    logic                         last;
  } grp_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd97 && c <= 8'd102) ||
           (c >= 8'd65 && c <= 8'd70);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'd48 && c <= 8'd57) begin
      d = c - 8'd48;
    end else if (c >= 8'd97 && c <= 8'd102) begin
      d = c - 8'd87;
    end else if (c >= 8'd65 && c <= 8'd70) begin
      d = c - 8'd55;
    end
    return d[3:0];
  endfunction

  // Decoded values that stay escaped: alphanumerics and URL punctuation.
  function automatic logic keeps_escape(input logic [7:0] v);
    logic k;
    k = (v >= 8'd48 && v <= 8'd57) || (v >= 8'd97 && v <= 8'd122) ||
        (v >= 8'd65 && v <= 8'd90);
    unique case (v)
      8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,
      8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F,
      8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5F: k = 1'b1;
      default: k = k;
    endcase
    return k;
  endfunction

endpackage

>>> src/urlpd_decode.sv
// ----------------------------------------------------------------------------
// urlpd_decode
// Escape tracking state and the per-item decode into a group of result bytes.
// ----------------------------------------------------------------------------
module urlpd_decode import urlpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       take,
  output grp_t       grp
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] first_digit, first_digit_next;

  logic [1:0] pre_n;
  logic [7:0] pre0, pre1;
  logic       do_plain;
  logic       pl_emit;
  logic [7:0] pl_byte;
  logic [7:0] dec_val;
  logic       b_hex;

  assign b_hex   = is_hex(in_byte);
  assign dec_val = {hex_val(first_digit), hex_val(in_byte)};

  // plain-text handling of the current byte
  always_comb begin
    pl_emit = 1'b1;
    pl_byte = in_byte;
    if (in_byte == CH_PERCENT) begin
      pl_emit = in_last;
    end else if (in_byte == CH_PLUS) begin
      pl_byte = CH_SPACE;
    end
  end

  always_comb begin
    pre_n            = 2'd0;
    pre0             = CH_PERCENT;
    pre1             = first_digit;
    do_plain         = 1'b0;
    phase_next       = PH_IDLE;
    first_digit_next = first_digit;
    grp.cnt          = 2'd0;
    grp.data         = '0;
    grp.last         = in_last;
    unique case (phase)
      PH_PCT: begin
        if (b_hex) begin
          if (in_last) begin
            grp.cnt     = 2'd2;
            grp.data[0] = CH_PERCENT;
            grp.data[1] = in_byte;
          end else begin
            phase_next       = PH_DIGIT;
            first_digit_next = in_byte;
          end
        end else begin
          pre_n    = 2'd1;
          do_plain = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (b_hex) begin
          if (keeps_escape(dec_val)) begin
            grp.cnt     = 2'd3;
            grp.data[0] = CH_PERCENT;
            grp.data[1] = first_digit;
            grp.data[2] = in_byte;
          end else begin
            grp.cnt     = 2'd1;
            grp.data[0] = dec_val;
          end
        end else begin
          pre_n    = 2'd2;
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase
    if (do_plain) begin
      grp.data[0] = pre0;
      grp.data[1] = pre1;
      grp.data[pre_n] = pl_byte;
      grp.cnt = pre_n + {1'b0, pl_emit};
      if (in_byte == CH_PERCENT && !in_last) begin
        phase_next = PH_PCT;
      end
    end
    if (in_last) begin
      phase_next = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      first_digit <= 8'd0;
    end else if (take) begin
      phase       <= phase_next;
      first_digit <= first_digit_next;
    end
  end

endmodule

>>> src/urlpd_outq.sv
// ----------------------------------------------------------------------------
// urlpd_outq
// Group buffer of up to three bytes and the output register, one byte a cycle while out_ready allows.
// ----------------------------------------------------------------------------
module urlpd_outq import urlpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  grp_t       grp_in,
  input  logic       load,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  grp_t q;
  logic pop;

  assign pop      = (q.cnt != 2'd0) && (!out_valid || out_ready);
  assign can_load = (q.cnt == 2'd0) || (q.cnt == 2'd1 && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.cnt     <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        q <= grp_in;
      end else if (pop) begin
        q.cnt  <= q.cnt - 2'd1;
        q.data <= {8'd0, q.data[GrpDepth-1:1]};
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte <= q.data[0];
      out_last <= q.last && (q.cnt == 2'd1);
    end
  end

endmodule

>>> src/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming URL percent-decoder, one text byte per item.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while in_ready is high; results pass through the
// group buffer and then the output register. An item causes zero to three
// result bytes, handed on one a cycle while out_ready allows; in_ready stays
// low until the item's last byte moves on, so an item with one or no result
// leaves the input free while the output is taken. The output register lets
// a new item in while the previous result waits to be taken.
module url_percent_decoder import urlpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  grp_t grp;
  logic take;

  assign take = in_valid && in_ready;

  urlpd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .in_byte (in_byte),
    .in_last (in_last),
    .take    (take),
    .grp     (grp)
  );

  urlpd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .grp_in    (grp),
    .load      (take),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
